// File: hdl/jsu_pkg.sv
// Shared types, codes and helper functions of the JSON string unescape block.
`default_nettype none

package jsu_pkg;

    typedef enum logic [6:0] {
        MODE_IDLE  = 7'b0000001,
        MODE_BODY  = 7'b0000010,
        MODE_ESC   = 7'b0000100,
        MODE_HEX   = 7'b0001000,
        MODE_HI    = 7'b0010000,
        MODE_HIBS  = 7'b0100000,
        MODE_LOHEX = 7'b1000000
    } mode_t;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NO_QUOTE  = 3'd0;
    localparam logic [2:0] ERR_UNTERM    = 3'd1;
    localparam logic [2:0] ERR_TRUNC_ESC = 3'd2;
    localparam logic [2:0] ERR_BAD_U     = 3'd3;
    localparam logic [2:0] ERR_BAD_ESC   = 3'd4;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [20:0] REPL_CP = 21'h00FFFD;
    localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG = 6'b110111;
    // 0x10000 expressed in units of 1024
    localparam logic [10:0] SUPP_BASE_K = 11'd64;

    localparam int GROUP_DEPTH = 8;
    localparam int COUNT_W     = $clog2(GROUP_DEPTH + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] code;
        logic       last;
    } result_t;

    typedef struct packed {
        result_t [GROUP_DEPTH-1:0] ent;
        logic [COUNT_W-1:0]        count;
    } group_t;

    // {valid, value} of a hex digit character
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    // {valid, decoded byte} of a single-character escape
    function automatic logic [8:0] esc_map(input logic [7:0] b);
        logic [8:0] r;
        case (b)
            CH_QUOTE:     r = {1'b1, CH_QUOTE};
            CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
            CH_SLASH:     r = {1'b1, CH_SLASH};
            8'h62:        r = {1'b1, 8'h08};
            8'h66:        r = {1'b1, 8'h0C};
            8'h6E:        r = {1'b1, 8'h0A};
            8'h72:        r = {1'b1, 8'h0D};
            8'h74:        r = {1'b1, 8'h09};
            default:      r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/jsu_decode.sv
// Decoder state and the result group built for one accepted text byte.
`default_nettype none

module jsu_decode (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            accept,
    input  wire logic [7:0]      text_byte,
    input  wire logic            final_req,
    output jsu_pkg::group_t      group
);

    jsu_pkg::mode_t mode_reg, mode_next;
    logic [15:0] hex_value_reg, hex_value_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [9:0]  high_half_reg, high_half_next;

    logic             pre;
    logic             use_cp;
    logic [20:0]      cp;
    logic             use_single;
    jsu_pkg::result_t single_ent;
    logic             fail;
    logic [2:0]       fail_code;

    logic [4:0]  hd;
    logic [8:0]  em;
    logic [15:0] hex_shift;
    logic        shift_hi;
    logic        shift_lo;
    logic [10:0] pair_top;

    assign hd        = jsu_pkg::hex_digit(text_byte);
    assign em        = jsu_pkg::esc_map(text_byte);
    assign hex_shift = {hex_value_reg[11:0], hd[3:0]};
    assign shift_hi  = hex_shift[15:10] == jsu_pkg::HI_SURR_TAG;
    assign shift_lo  = hex_shift[15:10] == jsu_pkg::LO_SURR_TAG;
    assign pair_top  = {1'b0, high_half_reg} + jsu_pkg::SUPP_BASE_K;

    always_comb begin
        mode_next      = mode_reg;
        hex_value_next = hex_value_reg;
        hex_count_next = hex_count_reg;
        high_half_next = high_half_reg;
        pre            = 1'b0;
        use_cp         = 1'b0;
        cp             = jsu_pkg::REPL_CP;
        use_single     = 1'b0;
        single_ent     = '{kind: jsu_pkg::KIND_DATA, data: text_byte, code: 3'd0, last: 1'b0};
        fail           = 1'b0;
        fail_code      = jsu_pkg::ERR_NO_QUOTE;

        unique case (mode_reg)
            jsu_pkg::MODE_BODY, jsu_pkg::MODE_HI: begin
                if (mode_reg == jsu_pkg::MODE_HI && text_byte == jsu_pkg::CH_BACKSLASH) begin
                    if (final_req) begin
                        use_cp    = 1'b1;
                        fail      = 1'b1;
                        fail_code = jsu_pkg::ERR_TRUNC_ESC;
                    end else begin
                        mode_next = jsu_pkg::MODE_HIBS;
                    end
                end else begin
                    pre = mode_reg == jsu_pkg::MODE_HI;
                    if (text_byte == jsu_pkg::CH_QUOTE) begin
                        use_single      = 1'b1;
                        single_ent.kind = jsu_pkg::KIND_DONE;
                        single_ent.data = 8'd0;
                        mode_next       = jsu_pkg::MODE_IDLE;
                    end else if (text_byte == jsu_pkg::CH_BACKSLASH) begin
                        if (final_req) begin
                            fail      = 1'b1;
                            fail_code = jsu_pkg::ERR_TRUNC_ESC;
                        end else begin
                            mode_next = jsu_pkg::MODE_ESC;
                        end
                    end else begin
                        use_single = 1'b1;
                        if (final_req) begin
                            fail      = 1'b1;
                            fail_code = jsu_pkg::ERR_UNTERM;
                        end else begin
                            mode_next = jsu_pkg::MODE_BODY;
                        end
                    end
                end
            end
            jsu_pkg::MODE_ESC, jsu_pkg::MODE_HIBS: begin
                if (text_byte == jsu_pkg::CH_U) begin
                    if (final_req) begin
                        use_cp    = mode_reg == jsu_pkg::MODE_HIBS;
                        fail      = 1'b1;
                        fail_code = jsu_pkg::ERR_BAD_U;
                    end else begin
                        hex_value_next = 16'd0;
                        hex_count_next = 2'd0;
                        mode_next      = (mode_reg == jsu_pkg::MODE_HIBS) ?
                                         jsu_pkg::MODE_LOHEX : jsu_pkg::MODE_HEX;
                    end
                end else begin
                    pre = mode_reg == jsu_pkg::MODE_HIBS;
                    if (em[8]) begin
                        use_single      = 1'b1;
                        single_ent.data = em[7:0];
                        if (final_req) begin
                            fail      = 1'b1;
                            fail_code = jsu_pkg::ERR_UNTERM;
                        end else begin
                            mode_next = jsu_pkg::MODE_BODY;
                        end
                    end else begin
                        fail      = 1'b1;
                        fail_code = jsu_pkg::ERR_BAD_ESC;
                    end
                end
            end
            jsu_pkg::MODE_HEX, jsu_pkg::MODE_LOHEX: begin
                if (!hd[4]) begin
                    pre       = mode_reg == jsu_pkg::MODE_LOHEX;
                    fail      = 1'b1;
                    fail_code = jsu_pkg::ERR_BAD_U;
                end else begin
                    hex_value_next = hex_shift;
                    if (hex_count_reg == 2'd3) begin
                        hex_count_next = 2'd0;
                        if (mode_reg == jsu_pkg::MODE_LOHEX && shift_lo) begin
                            // surrogate pair: 0x10000 + (high << 10) + low
                            use_cp = 1'b1;
                            cp     = {pair_top, hex_shift[9:0]};
                            if (final_req) begin
                                fail      = 1'b1;
                                fail_code = jsu_pkg::ERR_UNTERM;
                            end else begin
                                mode_next = jsu_pkg::MODE_BODY;
                            end
                        end else begin
                            pre = mode_reg == jsu_pkg::MODE_LOHEX;
                            if (shift_hi) begin
                                if (final_req) begin
                                    use_cp    = 1'b1;
                                    fail      = 1'b1;
                                    fail_code = jsu_pkg::ERR_UNTERM;
                                end else begin
                                    high_half_next = hex_shift[9:0];
                                    mode_next      = jsu_pkg::MODE_HI;
                                end
                            end else begin
                                use_cp = 1'b1;
                                if (!shift_lo) begin
                                    cp = {5'd0, hex_shift};
                                end
                                if (final_req) begin
                                    fail      = 1'b1;
                                    fail_code = jsu_pkg::ERR_UNTERM;
                                end else begin
                                    mode_next = jsu_pkg::MODE_BODY;
                                end
                            end
                        end
                    end else begin
                        hex_count_next = hex_count_reg + 2'd1;
                        if (final_req) begin
                            pre       = mode_reg == jsu_pkg::MODE_LOHEX;
                            fail      = 1'b1;
                            fail_code = jsu_pkg::ERR_BAD_U;
                        end
                    end
                end
            end
            default: begin
                mode_next = jsu_pkg::MODE_IDLE;
                if (text_byte == jsu_pkg::CH_QUOTE) begin
                    if (final_req) begin
                        fail      = 1'b1;
                        fail_code = jsu_pkg::ERR_UNTERM;
                    end else begin
                        mode_next = jsu_pkg::MODE_BODY;
                    end
                end else begin
                    fail      = 1'b1;
                    fail_code = jsu_pkg::ERR_NO_QUOTE;
                end
            end
        endcase

        // any error drops the string and clears the escape state
        if (fail) begin
            mode_next      = jsu_pkg::MODE_IDLE;
            hex_value_next = 16'd0;
            hex_count_next = 2'd0;
            high_half_next = 10'd0;
        end
    end

    // UTF-8 bytes of the replacement character and of the code point
    logic [7:0] repl_b [0:3];
    logic [7:0] mid_b  [0:3];
    logic [2:0] mid_n;
    logic [3:0] pre_n;
    logic [3:0] total;

    assign repl_b[0] = {4'b1110, jsu_pkg::REPL_CP[15:12]};
    assign repl_b[1] = {2'b10, jsu_pkg::REPL_CP[11:6]};
    assign repl_b[2] = {2'b10, jsu_pkg::REPL_CP[5:0]};
    assign repl_b[3] = 8'd0;

    always_comb begin
        mid_b[0] = 8'd0;
        mid_b[1] = 8'd0;
        mid_b[2] = 8'd0;
        mid_b[3] = 8'd0;
        mid_n    = 3'd0;
        if (use_single) begin
            mid_b[0] = single_ent.data;
            mid_n    = 3'd1;
        end else if (use_cp) begin
            if (cp[20:7] == 14'd0) begin
                mid_b[0] = {1'b0, cp[6:0]};
                mid_n    = 3'd1;
            end else if (cp[20:11] == 10'd0) begin
                mid_b[0] = {3'b110, cp[10:6]};
                mid_b[1] = {2'b10, cp[5:0]};
                mid_n    = 3'd2;
            end else if (cp[20:16] == 5'd0) begin
                mid_b[0] = {4'b1110, cp[15:12]};
                mid_b[1] = {2'b10, cp[11:6]};
                mid_b[2] = {2'b10, cp[5:0]};
                mid_n    = 3'd3;
            end else begin
                mid_b[0] = {5'b11110, cp[20:18]};
                mid_b[1] = {2'b10, cp[17:12]};
                mid_b[2] = {2'b10, cp[11:6]};
                mid_b[3] = {2'b10, cp[5:0]};
                mid_n    = 3'd4;
            end
        end
    end

    assign pre_n = pre ? 4'd3 : 4'd0;
    assign total = pre_n + {1'b0, mid_n} + {3'd0, fail};

    always_comb begin
        logic [3:0] pos;
        logic [3:0] j;
        group.count = total;
        for (int i = 0; i < jsu_pkg::GROUP_DEPTH; i++) begin
            pos = 4'(i);
            j   = pos - pre_n;
            group.ent[i] = '{kind: jsu_pkg::KIND_DATA, data: 8'd0, code: 3'd0,
                             last: pos == total - 4'd1};
            if (pos < pre_n) begin
                group.ent[i].data = repl_b[pos[1:0]];
            end else if (j < {1'b0, mid_n}) begin
                group.ent[i].data = mid_b[j[1:0]];
                if (use_single) begin
                    group.ent[i].kind = single_ent.kind;
                end
            end else begin
                group.ent[i].kind = jsu_pkg::KIND_ERROR;
                group.ent[i].code = fail_code;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= jsu_pkg::MODE_IDLE;
            hex_value_reg <= 16'd0;
            hex_count_reg <= 2'd0;
            high_half_reg <= 10'd0;
        end else if (accept) begin
            mode_reg      <= mode_next;
            hex_value_reg <= hex_value_next;
            hex_count_reg <= hex_count_next;
            high_half_reg <= high_half_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/json_string_unescape.sv
// Streaming decoder of one quoted JSON string per run, with UTF-8 output.
//
// Input: one text byte per transaction on s_tdata; s_tlast marks the final
// byte of the text. Output: one result per transaction; m_tuser gives the
// kind (data byte, string complete, error), m_tdata the byte and error code,
// and m_tlast marks the last result caused by one input byte.
// Each accepted byte is decoded in its acceptance cycle into a group of up to
// eight results, held in a group buffer that drains one result per cycle into
// the output register when it can load; results pass through the group buffer
// and the output register before m_tvalid. A byte producing at most one result
// is taken every cycle while the output is not stalled; after one producing
// more, the next byte waits until its last result moves on. The input stays
// ready while the output register holds a stalled result, as long as the group
// buffer is empty. Reset (aresetn low, synchronous) empties both buffers and
// returns the decoder to awaiting an opening quote. A stalled receiver holds
// m_tvalid and the result until taken; the input backs up behind the group buffer.
`default_nettype none

module json_string_unescape (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // text_byte
    input  wire logic        s_tlast,   // final_req
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // data_byte [7:0], error_code [10:8], zero pad
    output logic [1:0]       m_tuser,   // kind
    output logic             m_tlast    // last
);

    jsu_pkg::group_t  group;
    jsu_pkg::result_t grp_reg [0:jsu_pkg::GROUP_DEPTH-1];
    logic [jsu_pkg::COUNT_W-1:0] grp_left_reg;
    jsu_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             out_load;
    logic             accept;

    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = (grp_left_reg == '0) ||
                      (grp_left_reg == jsu_pkg::COUNT_W'(1) && out_load);
    assign accept   = s_tvalid && s_tready;

    jsu_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .text_byte (s_tdata),
        .final_req (s_tlast),
        .group     (group)
    );

    // group buffer: load on acceptance, shift toward the head as results leave
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_left_reg <= '0;
        end else if (accept) begin
            grp_left_reg <= group.count;
        end else if (grp_left_reg != '0 && out_load) begin
            grp_left_reg <= grp_left_reg - jsu_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < jsu_pkg::GROUP_DEPTH; i++) begin
                grp_reg[i] <= group.ent[i];
            end
        end else if (grp_left_reg != '0 && out_load) begin
            for (int i = 0; i < jsu_pkg::GROUP_DEPTH - 1; i++) begin
                grp_reg[i] <= grp_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= grp_left_reg != '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= grp_reg[0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.code, out_reg.data};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

`default_nettype wire

// File: hdl/jsu_checker.sv
// Port-level checks of the JSON string unescape block and their binding.
`default_nettype none

module jsu_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined result kind");

    // completion and errors always close the results of their input byte
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != 2'd0 |-> m_tlast && m_tdata[7:0] == 8'd0)
        else $error("done or error not last, or carries data");

    a_data_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != 2'd2 |-> m_tdata[15:8] == 8'd0)
        else $error("error code set on a non-error result");

    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: bench/json_string_unescape_tb.sv
// Self-checking testbench of the JSON string unescape block: random and directed text bytes.
`timescale 1ns / 100ps

module json_string_unescape_tb;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } text_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // text_byte
    logic        s_tlast  = 1'b0;    // final_req
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // data_byte [7:0], error_code [10:8], zero pad
    logic [1:0]  m_tuser;            // kind
    logic        m_tlast;            // last

    text_item_t        text_fifo[$];
    jsu_pkg::result_t  decoded_fifo[$];
    jsu_pkg::result_t  step_out[$];
    logic [7:0]        draft[$];

    // decoder state mirrored from the block
    jsu_pkg::mode_t dec_mode;
    logic [15:0] hex_acc;
    logic [1:0]  hex_digits;
    logic [9:0]  high_bits;

    int          mismatch_count = 0;
    int          send_wait = 0;
    int          recv_wait = 0;
    logic        send_burst = 1'b0;
    logic        recv_burst = 1'b0;

    json_string_unescape i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    function automatic void put_result(logic [1:0] k, logic [7:0] d, logic [2:0] c);
        jsu_pkg::result_t r;
        if (step_out.size() >= jsu_pkg::GROUP_DEPTH) return;
        r.kind = k;
        r.data = d;
        r.code = c;
        r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void emit_code_point(logic [20:0] cp);
        if (cp < 21'h80) begin
            put_result(jsu_pkg::KIND_DATA, cp[7:0], 3'd0);
        end else if (cp < 21'h800) begin
            put_result(jsu_pkg::KIND_DATA, {3'b110, cp[10:6]}, 3'd0);
            put_result(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]}, 3'd0);
        end else if (cp < 21'h10000) begin
            put_result(jsu_pkg::KIND_DATA, {4'b1110, cp[15:12]}, 3'd0);
            put_result(jsu_pkg::KIND_DATA, {2'b10, cp[11:6]}, 3'd0);
            put_result(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]}, 3'd0);
        end else begin
            put_result(jsu_pkg::KIND_DATA, {5'b11110, cp[20:18]}, 3'd0);
            put_result(jsu_pkg::KIND_DATA, {2'b10, cp[17:12]}, 3'd0);
            put_result(jsu_pkg::KIND_DATA, {2'b10, cp[11:6]}, 3'd0);
            put_result(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]}, 3'd0);
        end
    endfunction

    function automatic void abort_string(logic [2:0] c);
        put_result(jsu_pkg::KIND_ERROR, 8'd0, c);
        dec_mode   = jsu_pkg::MODE_IDLE;
        hex_acc    = '0;
        hex_digits = '0;
        high_bits  = '0;
    endfunction

    function automatic void continue_or_unterm(logic fin);
        if (fin) abort_string(jsu_pkg::ERR_UNTERM);
        else dec_mode = jsu_pkg::MODE_BODY;
    endfunction

    function automatic int nibble_of(logic [7:0] b);
        if (b >= "0" && b <= "9") return b - "0";
        if (b >= "a" && b <= "f") return b - "a" + 10;
        if (b >= "A" && b <= "F") return b - "A" + 10;
        return -1;
    endfunction

    function automatic void body_char(logic [7:0] b, logic fin);
        if (b == jsu_pkg::CH_QUOTE) begin
            put_result(jsu_pkg::KIND_DONE, 8'd0, 3'd0);
            dec_mode = jsu_pkg::MODE_IDLE;
        end else if (b == jsu_pkg::CH_BACKSLASH) begin
            if (fin) abort_string(jsu_pkg::ERR_TRUNC_ESC);
            else dec_mode = jsu_pkg::MODE_ESC;
        end else begin
            put_result(jsu_pkg::KIND_DATA, b, 3'd0);
            continue_or_unterm(fin);
        end
    endfunction

    function automatic void escape_char(logic [7:0] b, logic fin);
        logic [7:0] c;
        case (b)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH: c = b;
            "b": c = 8'h08;
            "f": c = 8'h0C;
            "n": c = 8'h0A;
            "r": c = 8'h0D;
            "t": c = 8'h09;
            jsu_pkg::CH_U: begin
                if (fin) begin
                    abort_string(jsu_pkg::ERR_BAD_U);
                end else begin
                    hex_acc    = '0;
                    hex_digits = '0;
                    dec_mode   = jsu_pkg::MODE_HEX;
                end
                return;
            end
            default: begin
                abort_string(jsu_pkg::ERR_BAD_ESC);
                return;
            end
        endcase
        put_result(jsu_pkg::KIND_DATA, c, 3'd0);
        continue_or_unterm(fin);
    endfunction

    function automatic void close_unicode(logic [15:0] cp, logic fin);
        if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
            if (fin) begin
                emit_code_point(jsu_pkg::REPL_CP);
                abort_string(jsu_pkg::ERR_UNTERM);
            end else begin
                high_bits = cp[9:0];
                dec_mode  = jsu_pkg::MODE_HI;
            end
        end else if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
            emit_code_point(jsu_pkg::REPL_CP);
            continue_or_unterm(fin);
        end else begin
            emit_code_point({5'd0, cp});
            continue_or_unterm(fin);
        end
    endfunction

    function automatic void unicode_digit(logic [7:0] b, logic fin);
        int n;
        n = nibble_of(b);
        if (n < 0) begin
            abort_string(jsu_pkg::ERR_BAD_U);
            return;
        end
        hex_acc = {hex_acc[11:0], n[3:0]};
        if (hex_digits == 2'd3) begin
            hex_digits = 2'd0;
            close_unicode(hex_acc, fin);
        end else begin
            hex_digits = hex_digits + 2'd1;
            if (fin) abort_string(jsu_pkg::ERR_BAD_U);
        end
    endfunction

    // digits of the escape that may complete a surrogate pair
    function automatic void low_half_digit(logic [7:0] b, logic fin);
        int n;
        n = nibble_of(b);
        if (n < 0) begin
            emit_code_point(jsu_pkg::REPL_CP);
            abort_string(jsu_pkg::ERR_BAD_U);
            return;
        end
        hex_acc = {hex_acc[11:0], n[3:0]};
        if (hex_digits == 2'd3) begin
            hex_digits = 2'd0;
            if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                emit_code_point(21'h10000 + {1'b0, high_bits, hex_acc[9:0]});
                continue_or_unterm(fin);
            end else begin
                emit_code_point(jsu_pkg::REPL_CP);
                close_unicode(hex_acc, fin);
            end
        end else begin
            hex_digits = hex_digits + 2'd1;
            if (fin) begin
                emit_code_point(jsu_pkg::REPL_CP);
                abort_string(jsu_pkg::ERR_BAD_U);
            end
        end
    endfunction

    function automatic void decode_text_byte(logic [7:0] b, logic fin);
        jsu_pkg::result_t r;
        step_out.delete();
        case (dec_mode)
            jsu_pkg::MODE_BODY:  body_char(b, fin);
            jsu_pkg::MODE_ESC:   escape_char(b, fin);
            jsu_pkg::MODE_HEX:   unicode_digit(b, fin);
            jsu_pkg::MODE_HI: begin
                if (b == jsu_pkg::CH_BACKSLASH) begin
                    if (fin) begin
                        emit_code_point(jsu_pkg::REPL_CP);
                        abort_string(jsu_pkg::ERR_TRUNC_ESC);
                    end else begin
                        dec_mode = jsu_pkg::MODE_HIBS;
                    end
                end else begin
                    emit_code_point(jsu_pkg::REPL_CP);
                    body_char(b, fin);
                end
            end
            jsu_pkg::MODE_HIBS: begin
                if (b == jsu_pkg::CH_U) begin
                    if (fin) begin
                        emit_code_point(jsu_pkg::REPL_CP);
                        abort_string(jsu_pkg::ERR_BAD_U);
                    end else begin
                        hex_acc    = '0;
                        hex_digits = '0;
                        dec_mode   = jsu_pkg::MODE_LOHEX;
                    end
                end else begin
                    emit_code_point(jsu_pkg::REPL_CP);
                    escape_char(b, fin);
                end
            end
            jsu_pkg::MODE_LOHEX: low_half_digit(b, fin);
            default: begin
                dec_mode = jsu_pkg::MODE_IDLE;
                if (b == jsu_pkg::CH_QUOTE) begin
                    if (fin) abort_string(jsu_pkg::ERR_UNTERM);
                    else dec_mode = jsu_pkg::MODE_BODY;
                end else begin
                    abort_string(jsu_pkg::ERR_NO_QUOTE);
                end
            end
        endcase
        if (step_out.size() > 0) begin
            r = step_out.pop_back();
            r.last = 1'b1;
            step_out.push_back(r);
        end
        foreach (step_out[i]) decoded_fifo.push_back(step_out[i]);
    endfunction

    function automatic void push_text(logic [7:0] b, logic f);
        text_item_t t;
        t.ch  = b;
        t.fin = f;
        text_fifo.push_back(t);
    endfunction

    function automatic void push_ascii(string s, logic fin_last);
        for (int i = 0; i < s.len(); i++) push_text(s[i], fin_last && i == s.len() - 1);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10) return 8'h30 + {4'd0, v};
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, v} - 8'd10;
    endfunction

    function automatic void draft_u(logic [15:0] v);
        draft.push_back(jsu_pkg::CH_BACKSLASH);
        draft.push_back(jsu_pkg::CH_U);
        for (int i = 3; i >= 0; i--) draft.push_back(hex_char(v[i*4 +: 4]));
    endfunction

    // spread code points over the one-, two- and three-byte UTF-8 lengths and the surrogate range
    function automatic logic [15:0] pick_code_point();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 16'h7F);
            1:       return $urandom_range(16'h80, 16'h7FF);
            2:       return $urandom_range(0, 16'hFFFF);
            default: return $urandom_range(16'hD800, 16'hDFFF);
        endcase
    endfunction

    function automatic void draft_token();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                do b = $urandom_range(0, 255);
                while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BACKSLASH);
                draft.push_back(b);
            end
            4, 5: begin
                draft.push_back(jsu_pkg::CH_BACKSLASH);
                case ($urandom_range(0, 7))
                    0:       draft.push_back(jsu_pkg::CH_QUOTE);
                    1:       draft.push_back(jsu_pkg::CH_BACKSLASH);
                    2:       draft.push_back(jsu_pkg::CH_SLASH);
                    3:       draft.push_back("b");
                    4:       draft.push_back("f");
                    5:       draft.push_back("n");
                    6:       draft.push_back("r");
                    default: draft.push_back("t");
                endcase
            end
            6, 7: draft_u(pick_code_point());
            8: begin
                draft_u(16'hD800 | 16'($urandom_range(0, 1023)));
                draft_u(16'hDC00 | 16'($urandom_range(0, 1023)));
            end
            default: begin
                // high half followed by an escape of a random code point, which may or may not complete it
                draft_u(16'hD800 | 16'($urandom_range(0, 1023)));
                draft_u(pick_code_point());
            end
        endcase
    endfunction

    function automatic void make_string();
        int   pos;
        logic fin_last;
        draft.delete();
        draft.push_back(jsu_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 6)) draft_token();
        draft.push_back(jsu_pkg::CH_QUOTE);
        fin_last = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
            0: begin
                // cut short: the last kept byte ends the text
                pos = $urandom_range(0, draft.size() - 2);
                draft = draft[0:pos];
                fin_last = 1'b1;
            end
            1: begin
                pos = $urandom_range(1, draft.size() - 1);
                draft[pos] = $urandom_range(0, 255);
            end
            2: begin
                void'(draft.pop_back());
                draft.push_back(jsu_pkg::CH_BACKSLASH);
                draft.push_back($urandom_range(0, 255));
                draft.push_back(jsu_pkg::CH_QUOTE);
            end
            3: begin
                repeat ($urandom_range(1, 3))
                    push_text($urandom_range(0, 255), $urandom_range(0, 1));
            end
            default: ;
        endcase
        foreach (draft[i]) push_text(draft[i], fin_last && i == draft.size() - 1);
    endfunction

    always @(posedge aclk) begin : drive_text
        text_item_t nxt;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            send_wait  <= 0;
            dec_mode   = jsu_pkg::MODE_IDLE;
            hex_acc    = '0;
            hex_digits = '0;
            high_bits  = '0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_text_byte(s_tdata, s_tlast);
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait != 0) begin
                    s_tvalid  <= 1'b0;
                    send_wait <= send_wait - 1;
                end else if (text_fifo.size() != 0) begin
                    nxt = text_fifo.pop_front();
                    s_tdata  <= nxt.ch;
                    s_tlast  <= nxt.fin;
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 31) == 0) send_burst <= !send_burst;
                    send_wait <= send_burst ? 0 : $urandom_range(0, 17);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_results
        jsu_pkg::result_t want;
        int               w;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (decoded_fifo.size() == 0) begin
                    $display("%0t: unexpected transaction, kind %0d data %h code %0d last %0d",
                             $time, m_tuser, m_tdata[7:0], m_tdata[10:8], m_tlast);
                    mismatch_count++;
                end else begin
                    want = decoded_fifo.pop_front();
                    if (m_tuser !== want.kind) begin
                        $display("%0t: kind expected %0d, got %0d", $time, want.kind, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata[7:0] !== want.data) begin
                        $display("%0t: data byte expected %h, got %h",
                                 $time, want.data, m_tdata[7:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[10:8] !== want.code) begin
                        $display("%0t: error code expected %0d, got %0d",
                                 $time, want.code, m_tdata[10:8]);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: last expected %0d, got %0d", $time, want.last, m_tlast);
                        mismatch_count++;
                    end
                end
                if ($urandom_range(0, 31) == 0) recv_burst <= !recv_burst;
                w = recv_burst ? 0 : $urandom_range(0, 17);
                m_tready  <= (w == 0);
                recv_wait <= w;
            end else if (recv_wait != 0) begin
                recv_wait <= recv_wait - 1;
                m_tready  <= (recv_wait == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        // bytes outside a string, then a string ending in the middle of an escape
        push_ascii("A", 1'b0);
        push_ascii("\"", 1'b1);
        push_text(jsu_pkg::CH_QUOTE, 1'b0);
        push_text(8'hFF, 1'b0);
        push_ascii("\\uD83D\\ude00\\uDBFF", 1'b0);
        push_text(8'h00, 1'b0);
        push_ascii("\\", 1'b1);
        while (text_fifo.size() < 450) make_string();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        while (text_fifo.size() != 0 || s_tvalid || decoded_fifo.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
hdl/jsu_pkg.sv
hdl/jsu_decode.sv
hdl/json_string_unescape.sv
hdl/jsu_checker.sv
bench/json_string_unescape_tb.sv
